@@ design/expert_route_grouper_core_assert.svh @@
// assertion macros for the route grouper, clocked on clk; ERG_ASSERT is off during reset
`ifndef EXPERT_ROUTE_GROUPER_CORE_ASSERT_SVH
`define EXPERT_ROUTE_GROUPER_CORE_ASSERT_SVH

// property held at every edge outside reset
`define ERG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at edges only
`define ERG_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/erg_pkg.sv @@
// ------------------------------------------------------------------
// erg_pkg
// shared sizes, status codes and types of the expert route grouper
// ------------------------------------------------------------------
package erg_pkg;

	localparam int MAX_ROUTES           = 4096;
	localparam int MAX_EXPERTS          = 256;
	localparam int MAX_ROUTES_PER_TOKEN = 16;

	localparam int CNT_W = 13;  // route count, 0..MAX_ROUTES+1
	localparam int IDX_W = 12;  // route position
	localparam int EXP_W = 8;   // expert id
	localparam int NE_W  = 9;   // expert count
	localparam int RPT_W = 5;   // routes per token register
	localparam int SLT_W = 4;   // slot within token

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_MULTIPLE = 2'd3;

	localparam logic CFG_RPT = 1'b0;
	localparam logic CFG_NE  = 1'b1;

	typedef logic [CNT_W-1:0] cnt_t;

endpackage

@@ design/erg_div.sv @@
// ------------------------------------------------------------------
// erg_div
// restoring remainder unit, one dividend bit per cycle
// ------------------------------------------------------------------
module erg_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  erg_pkg::cnt_t         dividend,
	input  logic [erg_pkg::RPT_W-1:0] divisor,
	output logic                  done,
	output logic [erg_pkg::RPT_W-1:0] rem
);
	import erg_pkg::*;

	logic             busy_q;
	logic [3:0]       step_q;
	cnt_t             num_q;
	logic [RPT_W:0]   rem_q;
	logic [RPT_W:0]   trial;

	assign trial = {rem_q[RPT_W-1:0], num_q[CNT_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'(CNT_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[CNT_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= trial - {1'b0, divisor};
			else
				rem_q <= trial;
		end
	end

	assign rem = rem_q[RPT_W-1:0];

endmodule

@@ design/expert_route_grouper_core.sv @@
// ------------------------------------------------------------------
// expert_route_grouper_core
// groups routes by expert with a stable counting sort over memories
// ------------------------------------------------------------------
// s_* carries items: tuser = kind (0 load, 1 read), tlast = last route,
// tdata = expert_choice then read_index. m_* returns one result per read
// and per build; a load without tlast returns nothing.
// an accepted load goes to the choice buffer while it has room; a read passes
// the memory read registers and S_RD to the output register. a build (load
// with tlast) runs: a remainder check, then on success a clear pass over
// expert_count cursors, a count pass over the routes, a prefix pass over the
// experts plus a final offset write, a scatter pass and a commit state; each
// route reads the choice buffer, then the cursor memory, then writes back.
// on any failed check the committed tables are left alone.
// one item is worked at a time; s_tready is low while a build runs or a
// result waits in the output register, so a stalled receiver stalls input.
// reset clears counters and committed totals; the tables need no clearing
// since reads beyond the committed totals return zero. cfg writes apply at once;
// the user must make them only while the block is idle, the block has no guard.
// ------------------------------------------------------------------
module expert_route_grouper_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // expert_choice[31:0], read_index[43:32]
	input  logic        s_tuser,   // kind
	input  logic        s_tlast,   // last_route
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], grouped_expert[9:2], grouped_token_row[21:10],
	// grouped_slot[25:22], grouped_original[37:26], position_of_original[49:38],
	// active_expert[57:50], expert_offset[70:58], route_total[83:71],
	// active_total[92:84]
	output logic [95:0] m_tdata
);
	import erg_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_CLR  = 4'd3;
	localparam logic [3:0] S_CNT  = 4'd4;
	localparam logic [3:0] S_PFX  = 4'd5;
	localparam logic [3:0] S_SCT  = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;

	logic [3:0]        st_q;
	logic [1:0]        ph_q;
	logic [RPT_W-1:0]  rpt_q;
	logic [NE_W-1:0]   ne_q;
	cnt_t              lc_q;
	logic              bad_q;
	logic [EXP_W-1:0]  max_q;
	cnt_t              cr_q;
	logic [NE_W-1:0]   ca_q;
	logic [NE_W-1:0]   ce_q;
	logic [IDX_W-1:0]  i_q;
	logic [EXP_W-1:0]  e_q;
	logic [EXP_W-1:0]  ex_q;
	cnt_t              acc_q;
	logic [NE_W-1:0]   na_q;
	logic [IDX_W-1:0]  row_q;
	logic [SLT_W-1:0]  slot_q;
	logic              f_grp_q, f_act_q, f_off_q;
	logic              m_valid_q;
	logic [95:0]       m_data_q;

	logic              s_acc;
	logic [31:0]       choice;
	logic [IDX_W-1:0]  ridx;
	logic              div_start, div_done;
	logic [RPT_W-1:0]  div_rem;
	logic              last_i, last_e;
	logic [1:0]        chk_status;

	// memories
	logic [EXP_W-1:0]  cbuf_mem [MAX_ROUTES];
	cnt_t              cnt_mem  [MAX_EXPERTS];
	cnt_t              off_mem  [MAX_EXPERTS+1];
	logic [35:0]       grp_mem  [MAX_ROUTES];
	logic [IDX_W-1:0]  inv_mem  [MAX_ROUTES];
	logic [EXP_W-1:0]  act_mem  [MAX_EXPERTS];

	logic              cbuf_we;
	logic [IDX_W-1:0]  cbuf_wa;
	logic [EXP_W-1:0]  cbuf_wd, cbuf_rd;
	logic              cnt_we;
	logic [EXP_W-1:0]  cnt_wa, cnt_ra;
	cnt_t              cnt_wd, cnt_rd;
	logic              off_we;
	logic [NE_W-1:0]   off_wa;
	cnt_t              off_wd, off_rd;
	logic              grp_we;
	logic [IDX_W-1:0]  grp_wa;
	logic [35:0]       grp_wd, grp_rd;
	logic              inv_we;
	logic [IDX_W-1:0]  inv_rd;
	logic              act_we;
	logic [EXP_W-1:0]  act_rd;

	assign s_tready = (st_q == S_IDLE) && !m_valid_q;
	assign s_acc    = s_tvalid && s_tready;
	assign choice   = s_tdata[31:0];
	assign ridx     = s_tdata[43:32];
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign last_i = ({1'b0, i_q} == lc_q - cnt_t'(1));
	assign last_e = ({1'b0, e_q} == ne_q - NE_W'(1));
	assign div_start = s_acc && !s_tuser && s_tlast;

	erg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lc_q + cnt_t'(lc_q < cnt_t'(MAX_ROUTES))),
		.divisor  (rpt_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		if (lc_q > cnt_t'(MAX_ROUTES) || ne_q > NE_W'(MAX_EXPERTS))
			chk_status = ST_OVERFLOW;
		else if (rpt_q == '0 || rpt_q > RPT_W'(MAX_ROUTES_PER_TOKEN) || div_rem != '0)
			chk_status = ST_MULTIPLE;
		else if (bad_q || ne_q == '0 || {1'b0, max_q} >= ne_q)
			chk_status = ST_RANGE;
		else
			chk_status = ST_OK;
	end

	// memory port control
	always_comb begin
		cbuf_we = s_acc && !s_tuser && (lc_q < cnt_t'(MAX_ROUTES));
		cbuf_wa = lc_q[IDX_W-1:0];
		cbuf_wd = (choice[31:EXP_W] != '0) ? '0 : choice[EXP_W-1:0];
		cnt_we  = 1'b0;
		cnt_wa  = ex_q;
		cnt_wd  = cnt_rd + cnt_t'(1);
		cnt_ra  = cbuf_rd;
		off_we  = 1'b0;
		off_wa  = {1'b0, e_q};
		off_wd  = acc_q;
		grp_we  = 1'b0;
		grp_wa  = cnt_rd[IDX_W-1:0];
		grp_wd  = {i_q, slot_q, row_q, ex_q};
		inv_we  = 1'b0;
		act_we  = 1'b0;
		case (st_q)
			S_CLR: begin
				cnt_we = 1'b1;
				cnt_wa = e_q;
				cnt_wd = '0;
			end
			S_CNT: begin
				cnt_we = (ph_q == 2'd2);
			end
			S_PFX: begin
				cnt_ra = e_q;
				if (ph_q == 2'd1) begin
					cnt_we = 1'b1;
					cnt_wa = e_q;
					cnt_wd = acc_q;
					off_we = 1'b1;
					act_we = (cnt_rd != '0);
				end else if (ph_q == 2'd2) begin
					off_we = 1'b1;
					off_wa = ne_q;
				end
			end
			S_SCT: begin
				if (ph_q == 2'd2) begin
					cnt_we = 1'b1;
					grp_we = 1'b1;
					inv_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cbuf_we)
			cbuf_mem[cbuf_wa] <= cbuf_wd;
		cbuf_rd <= cbuf_mem[i_q];
	end

	// a route's cursor read follows the previous route's write-back, so it sees the new cursor
	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (off_we)
			off_mem[off_wa] <= off_wd;
		off_rd <= off_mem[ridx[NE_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (grp_we)
			grp_mem[grp_wa] <= grp_wd;
		grp_rd <= grp_mem[ridx];
	end

	always_ff @(posedge clk) begin
		if (inv_we)
			inv_mem[i_q] <= cnt_rd[IDX_W-1:0];
		inv_rd <= inv_mem[ridx];
	end

	always_ff @(posedge clk) begin
		if (act_we)
			act_mem[na_q[EXP_W-1:0]] <= e_q;
		act_rd <= act_mem[ridx[EXP_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			ph_q      <= '0;
			rpt_q     <= RPT_W'(1);
			ne_q      <= NE_W'(MAX_EXPERTS);
			lc_q      <= '0;
			bad_q     <= 1'b0;
			max_q     <= '0;
			cr_q      <= '0;
			ca_q      <= '0;
			ce_q      <= '0;
			i_q       <= '0;
			e_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_RPT)
					rpt_q <= cfg_wdata[RPT_W-1:0];
				else
					ne_q <= cfg_wdata;
			end
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (s_acc && s_tuser) begin
						st_q <= S_RD;
					end else if (s_acc) begin
						if (choice[31:EXP_W] != '0)
							bad_q <= 1'b1;
						else if (lc_q < cnt_t'(MAX_ROUTES) && choice[EXP_W-1:0] > max_q)
							max_q <= choice[EXP_W-1:0];
						if (lc_q < cnt_t'(MAX_ROUTES))
							lc_q <= lc_q + cnt_t'(1);
						else
							lc_q <= cnt_t'(MAX_ROUTES + 1);
						if (s_tlast)
							st_q <= S_CHK;
					end
				end
				S_RD: begin
					m_valid_q <= 1'b1;
					st_q      <= S_IDLE;
				end
				S_CHK: begin
					if (div_done) begin
						e_q <= '0;
						i_q <= '0;
						ph_q <= '0;
						if (chk_status != ST_OK) begin
							m_valid_q <= 1'b1;
							lc_q  <= '0;
							bad_q <= 1'b0;
							max_q <= '0;
							st_q  <= S_IDLE;
						end else begin
							st_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					e_q <= e_q + EXP_W'(1);
					if (last_e) begin
						e_q  <= '0;
						st_q <= (lc_q == '0) ? S_PFX : S_CNT;
					end
				end
				S_CNT, S_SCT: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						i_q  <= i_q + IDX_W'(1);
						if (last_i) begin
							i_q  <= '0;
							st_q <= (st_q == S_CNT) ? S_PFX : S_FIN;
						end
					end
				end
				S_PFX: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd1) begin
						e_q <= e_q + EXP_W'(1);
						if (!last_e)
							ph_q <= '0;
					end else if (ph_q == 2'd2) begin
						ph_q <= '0;
						st_q <= (lc_q == '0) ? S_FIN : S_SCT;
					end
				end
				S_FIN: begin
					cr_q      <= lc_q;
					ca_q      <= na_q;
					ce_q      <= ne_q;
					lc_q      <= '0;
					bad_q     <= 1'b0;
					max_q     <= '0;
					m_valid_q <= 1'b1;
					st_q      <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (st_q == S_CNT && ph_q == 2'd1)
			ex_q <= cbuf_rd;
		if (st_q == S_SCT && ph_q == 2'd1)
			ex_q <= cbuf_rd;
		if (st_q == S_CHK) begin
			acc_q  <= '0;
			na_q   <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end
		if (st_q == S_PFX && ph_q == 2'd1) begin
			acc_q <= acc_q + cnt_rd;
			if (cnt_rd != '0)
				na_q <= na_q + NE_W'(1);
		end
		if (st_q == S_SCT && ph_q == 2'd2) begin
			if ({1'b0, slot_q} == rpt_q - RPT_W'(1)) begin
				slot_q <= '0;
				row_q  <= row_q + IDX_W'(1);
			end else begin
				slot_q <= slot_q + SLT_W'(1);
			end
		end
		if (s_acc && s_tuser) begin
			f_grp_q <= ({1'b0, ridx} < cr_q);
			f_act_q <= ({1'b0, ridx} < {4'd0, ca_q});
			f_off_q <= ({1'b0, ridx} <= {4'd0, ce_q}) && (ridx != '0);
		end
		if (st_q == S_RD) begin
			m_data_q <= {3'd0, 9'(ca_q), cr_q,
				f_off_q ? off_rd : cnt_t'(0),
				f_act_q ? act_rd : EXP_W'(0),
				f_grp_q ? inv_rd : IDX_W'(0),
				f_grp_q ? grp_rd : 36'd0,
				ST_OK};
		end else if (st_q == S_CHK && div_done && chk_status != ST_OK) begin
			m_data_q <= {3'd0, ca_q, cr_q, 69'd0, chk_status};
		end else if (st_q == S_FIN) begin
			m_data_q <= {3'd0, na_q, lc_q, 69'd0, ST_OK};
		end
	end

endmodule

@@ design/erg_check.sv @@
// ------------------------------------------------------------------
// erg_check
// port-level checks of the expert route grouper
// ------------------------------------------------------------------
`include "expert_route_grouper_core_assert.svh"

module erg_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	`ERG_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped while stalled")
	`ERG_ASSERT(a_one_item, m_tvalid |-> !s_tready, "input taken while result pending")
	`ERG_ASSERT(a_read_lat, s_tvalid && s_tready && s_tuser |=> ##1 m_tvalid, "read result late")
	`ERG_ASSERT(a_load_quiet, s_tvalid && s_tready && !s_tuser && !s_tlast |=> ##1 !m_tvalid, "load gave a result")
	`ERG_ASSERT_NR(a_rst, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind expert_route_grouper_core erg_check u_erg_check (.*);

@@ test/tb_expert_route_grouper_core.sv @@
// ------------------------------------------------------------------
// tb_expert_route_grouper_core
// self-checking bench: loads route batches, builds and reads back the
// grouped tables, checks every result against a local counting sort
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_expert_route_grouper_core;
	import erg_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct {
		logic [1:0]  status;
		logic [7:0]  g_expert;
		logic [11:0] g_row;
		logic [3:0]  g_slot;
		logic [11:0] g_orig;
		logic [11:0] inv_pos;
		logic [7:0]  act_expert;
		logic [12:0] offset;
		logic [12:0] routes;
		logic [8:0]  actives;
	} grp_result_t;

	// grouping predictor and store of expected results
	class grouping_scoreboard;
		int unsigned rpt, ne;
		bit [7:0] choices[MAX_ROUTES];
		int unsigned n_loaded;
		bit bad_seen;
		int unsigned offsets[MAX_EXPERTS+1];
		int unsigned cursors[MAX_EXPERTS];
		bit [7:0] t_expert[MAX_ROUTES];
		int unsigned t_row[MAX_ROUTES], t_slot[MAX_ROUTES], t_orig[MAX_ROUTES];
		int unsigned t_inv[MAX_ROUTES];
		int unsigned act_list[MAX_EXPERTS];
		int unsigned c_routes, c_active, c_experts;
		grp_result_t expected_q[$];
		int errors, builds, reads;
		int status_seen[4];

		function new();
			rpt = 1;
			ne = 256;
			n_loaded = 0;
			bad_seen = 0;
			foreach (offsets[i]) offsets[i] = 0;
			c_routes = 0;
			c_active = 0;
			c_experts = 0;
			errors = 0;
		endfunction

		function void write_reg(logic addr, logic [8:0] value);
			if (addr == CFG_RPT) rpt = value[4:0];
			else ne = value;
		endfunction

		function logic [1:0] build_groups();
			int unsigned act, g, ex;
			if (n_loaded > MAX_ROUTES || ne > MAX_EXPERTS) return ST_OVERFLOW;
			if (rpt == 0 || rpt > MAX_ROUTES_PER_TOKEN || (n_loaded % rpt) != 0)
				return ST_MULTIPLE;
			if (bad_seen) return ST_RANGE;
			for (int i = 0; i < n_loaded; i++)
				if (choices[i] >= ne) return ST_RANGE;
			foreach (offsets[i]) offsets[i] = 0;
			for (int i = 0; i < n_loaded; i++) offsets[choices[i]+1]++;
			for (int e = 0; e < ne; e++) begin
				offsets[e+1] += offsets[e];
				cursors[e] = offsets[e];
			end
			for (int i = 0; i < n_loaded; i++) begin
				ex = choices[i];
				g = cursors[ex]++;
				t_expert[g] = 8'(ex);
				t_row[g] = i / rpt;
				t_slot[g] = i % rpt;
				t_orig[g] = i;
				t_inv[i] = g;
			end
			act = 0;
			for (int e = 0; e < ne; e++)
				if (offsets[e] != offsets[e+1]) act_list[act++] = e;
			c_routes = n_loaded;
			c_active = act;
			c_experts = ne;
			return ST_OK;
		endfunction

		function void note_item(logic kind, logic [31:0] choice, logic last,
				logic [11:0] idx);
			grp_result_t r;
			logic [7:0] stored;
			r = '{default: '0};
			if (kind == KIND_LOAD) begin
				stored = '0;
				if (choice[31] || choice >= MAX_EXPERTS) bad_seen = 1;
				else stored = choice[7:0];
				if (n_loaded < MAX_ROUTES) choices[n_loaded++] = stored;
				else n_loaded = MAX_ROUTES + 1;
				if (!last) return;
				r.status = build_groups();
				n_loaded = 0;
				bad_seen = 0;
				builds++;
				status_seen[r.status]++;
			end else begin
				reads++;
				if (idx < c_routes) begin
					r.g_expert = t_expert[idx];
					r.g_row = 12'(t_row[idx]);
					r.g_slot = 4'(t_slot[idx]);
					r.g_orig = 12'(t_orig[idx]);
					r.inv_pos = 12'(t_inv[idx]);
				end
				if (idx < c_active) r.act_expert = 8'(act_list[idx]);
				if (idx <= c_experts) r.offset = 13'(offsets[idx]);
			end
			r.routes = 13'(c_routes);
			r.actives = 9'(c_active);
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [95:0] d);
			grp_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no expectation: %h", d);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp("status", e.status, d[1:0]);
			cmp("grouped_expert", e.g_expert, d[9:2]);
			cmp("grouped_token_row", e.g_row, d[21:10]);
			cmp("grouped_slot", e.g_slot, d[25:22]);
			cmp("grouped_original", e.g_orig, d[37:26]);
			cmp("position_of_original", e.inv_pos, d[49:38]);
			cmp("active_expert", e.act_expert, d[57:50]);
			cmp("expert_offset", e.offset, d[70:58]);
			cmp("route_total", e.routes, d[83:71]);
			cmp("active_total", e.actives, d[92:84]);
		endfunction

		function void cmp(string field, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [8:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;

	grouping_scoreboard sb;
	int cycles;
	int sent;
	int burst_left;
	bit hold_req;
	bit hold_busy;

	expert_route_grouper_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// note accepted items and check accepted results
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_item(s_tuser, s_tdata[31:0], s_tlast, s_tdata[43:32]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// receiver: own stall pattern, plus a long hold-off on request
	initial begin
		int mode;
		int left;
		m_tready = 0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_busy) begin
				hold_busy = 1;
				m_tready <= 0;
				repeat (400) @(negedge clk);
				hold_req = 0;
				hold_busy = 0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(5, 60);
			end
			left--;
			case (mode)
				0: m_tready <= 1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 1) == 0);
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	task automatic send(logic kind, logic [31:0] choice, logic last, logic [11:0] idx);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				@(negedge clk);
				s_tvalid <= 0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tlast <= last;
		s_tdata <= {4'b0, idx, choice};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	task automatic drain();
		stop_sending();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic addr, logic [8:0] value);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_reg(addr, value);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] good_choice();
		int unsigned top;
		top = (sb.ne >= 1 && sb.ne <= 256) ? sb.ne - 1 : 255;
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, top < 3 ? top : 3);
		return $urandom_range(0, top);
	endfunction

	function automatic logic [31:0] bad_choice();
		case ($urandom_range(0, 3))
			0: return $urandom() | 32'h8000_0000;
			1: return $urandom_range(256, 32'h7fff_ffff);
			2: return $urandom();
			default: return $urandom_range(sb.ne < 256 ? sb.ne : 255, 255);
		endcase
	endfunction

	// batch of n loads; bad_at >= 0 puts a likely broken choice there
	task automatic send_batch(int n, int bad_at);
		for (int i = 0; i < n; i++)
			send(KIND_LOAD, i == bad_at ? bad_choice() : good_choice(), i == n - 1,
				12'($urandom()));
	endtask

	task automatic send_reads(int k);
		logic [11:0] idx;
		for (int i = 0; i < k; i++) begin
			case ($urandom_range(0, 5))
				0: idx = 12'($urandom());
				1: idx = 12'($urandom_range(0, sb.c_experts + 1));
				2: idx = 12'($urandom_range(0, sb.c_active + 1));
				default: idx = 12'($urandom_range(0, sb.c_routes + 1));
			endcase
			send(KIND_READ, $urandom(), $urandom_range(0, 7) == 0, idx);
		end
	endtask

	task automatic random_phase(int items);
		int start, k, r;
		start = sent;
		while (sent - start < items) begin
			r = $urandom_range(0, 99);
			k = (sb.rpt >= 1 && sb.rpt <= 16) ? sb.rpt : 1;
			if (r < 55)
				send_batch(k * $urandom_range(1, 6), -1);
			else if (r < 63)
				send_batch(k * $urandom_range(1, 4), $urandom_range(0, k - 1));
			else if (r < 70)
				send_batch(k * $urandom_range(1, 4) + $urandom_range(1, 3), -1);
			else
				send_reads($urandom_range(1, 8));
		end
	endtask

	initial begin
		int unsigned rpt_set[8] = '{1, 16, 2, 5, 3, 0, 20, 4};
		int unsigned ne_set[8]  = '{256, 1, 37, 256, 9, 256, 300, 0};
		sb = new();
		cycles = 0;
		sent = 0;
		burst_left = 0;
		hold_req = 0;
		hold_busy = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_addr = CFG_RPT;
		cfg_wdata = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = KIND_LOAD;
		s_tlast = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty tables, field extremes, the range and multiple checks failing
		send(KIND_READ, 0, 0, 0);
		send(KIND_READ, 32'hffff_ffff, 1, 12'hfff);
		send(KIND_LOAD, 0, 0, 0);
		send(KIND_LOAD, 255, 0, 0);
		send(KIND_LOAD, 3, 0, 0);
		send(KIND_LOAD, 3, 1, 12'hfff);
		send(KIND_READ, 0, 0, 1);
		send(KIND_READ, 0, 0, 3);
		send(KIND_READ, 0, 0, 256);
		send(KIND_READ, 0, 0, 4);
		send(KIND_LOAD, 32'h8000_0000, 1, 0);
		send(KIND_LOAD, 32'h7fff_ffff, 0, 0);
		send(KIND_LOAD, 256, 1, 0);
		send(KIND_LOAD, 32'hffff_ffff, 1, 0);
		drain();
		write_reg(CFG_RPT, 2);
		write_reg(CFG_NE, 4);
		send(KIND_LOAD, 1, 0, 0);
		send(KIND_LOAD, 2, 0, 0);
		send(KIND_LOAD, 3, 1, 0);
		send(KIND_LOAD, 1, 0, 0);
		send(KIND_LOAD, 4, 1, 0);
		send(KIND_LOAD, 3, 0, 0);
		send(KIND_LOAD, 0, 1, 0);
		send_reads(4);
		drain();

		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_RPT, 9'(rpt_set[p]));
			write_reg(CFG_NE, 9'(ne_set[p]));
			if (p == 2) hold_req = 1;
			random_phase(p < 5 ? 160 : 25);
			drain();
		end

		$display("%0d builds (ok %0d, range %0d, overflow %0d, multiple %0d), %0d reads",
			sb.builds, sb.status_seen[ST_OK], sb.status_seen[ST_RANGE],
			sb.status_seen[ST_OVERFLOW], sb.status_seen[ST_MULTIPLE], sb.reads);
		$display("%0d transactions sent over %0d cycles, 8 register settings", sent, cycles);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			if (sb.expected_q.size() != 0)
				$error("%0d expected results never arrived", sb.expected_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
